@@ rtl/mrcr_pkg.sv @@
// Shared types and constants for the matrix row/column rotator.
// No dependencies; imported by matrix_row_column_rotator.
package mrcr_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 5;
   localparam int COUNT_W   = 6;
   localparam int AMOUNT_W  = 8;
   localparam int DIV_CNT_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(AMOUNT_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_READ    = 2'd1,
      MODE_ROT_ROW = 2'd2,
      MODE_ROT_COL = 2'd3
   } mode_type;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_DECODE     = 7'b0000010,
      ST_DIVIDE     = 7'b0000100,
      ST_READ_LINE  = 7'b0001000,
      ST_WRITE_LINE = 7'b0010000,
      ST_READ_WAIT  = 7'b0100000,
      ST_FINISH     = 7'b1000000
   } state_type;

endpackage

@@ rtl/matrix_row_column_rotator.sv @@
// Matrix store with element load/read and circular row/column rotation.
// Depends on mrcr_pkg.
//
// One transaction at a time: req_stall is high from acceptance until the
// result has been placed in the output register (a waiting result does not
// block the next request). After decode, a rotation of length L finds
// amount mod L in the bit-serial remainder unit, then reads the line
// from the store into a line buffer and writes it back rotated, each pass
// ending with a pipeline drain, before the result is registered; a
// remainder of zero or L below 2 skips both passes. The store has no
// reset and is never cleared; an element must be loaded before it is read.
module matrix_row_column_rotator #(
   parameter int MAX_DIM = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [mrcr_pkg::IDX_W-1:0]          req_row_index,
   input  logic [mrcr_pkg::IDX_W-1:0]          req_col_index,
   input  logic signed [mrcr_pkg::DATA_W-1:0]  req_value,
   input  logic                                req_toward_start,
   input  logic [mrcr_pkg::AMOUNT_W-1:0]       req_amount,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mrcr_pkg::DATA_W-1:0]  rsp_read_value,
   output logic                                rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mrcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mrcr_pkg::COUNT_W-1:0]        csr_wdata
);
   import mrcr_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_DIM);
   localparam int LW    = $clog2(MAX_DIM + 1);
   localparam int CW    = (LW > COUNT_W) ? LW : COUNT_W;

   // storage
   logic [DATA_W-1:0] store [DEPTH];
   logic [DATA_W-1:0] line_buf [MAX_DIM];

   // control state
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] row_count_ff, col_count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               wr_pend_ff, wr_pend_in;

   // transaction registers
   mode_type            mode_ff, mode_in;
   logic                ok_ff, ok_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [AW-1:0]       stride_ff, stride_in;
   logic [CW-1:0]       len_ff, len_in;
   logic                toward_ff, toward_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       src_ff, src_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [AW-1:0]       line_addr_ff, line_addr_in;
   logic [KW-1:0]       rd_idx_ff, rd_idx_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic [DATA_W-1:0]   res_data_ff, res_data_in;
   logic                res_status_ff, res_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_status_ff, rsp_status_in;

   // memory ports
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [DATA_W-1:0] mem_q;
   logic              buf_we;
   logic [KW-1:0]     buf_raddr;
   logic [DATA_W-1:0] buf_q;

   // request decode
   logic          req_accept;
   logic [CW-1:0] rows_use, cols_use;
   logic          row_ok, col_ok;
   logic [AW-1:0] row_base;

   // remainder step
   logic [CW:0]   rem_sh;
   logic [CW-1:0] rem_step;
   logic [CW-1:0] src_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;

   assign rows_use = (CW'(row_count_ff) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(row_count_ff);
   assign cols_use = (CW'(col_count_ff) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(col_count_ff);
   assign row_ok   = CW'(req_row_index) < rows_use;
   assign col_ok   = CW'(req_col_index) < cols_use;
   assign row_base = AW'(req_row_index * MAX_DIM);

   always_comb begin
      mode_in   = mode_type'(req_mode);
      toward_in = req_toward_start;
      value_in  = req_value;
      ok_in     = 1'b0;
      base_in   = row_base;
      stride_in = AW'(1);
      len_in    = cols_use;
      unique case (mode_type'(req_mode))
         MODE_LOAD, MODE_READ: begin
            ok_in   = row_ok && col_ok;
            base_in = row_base + AW'(req_col_index);
         end
         MODE_ROT_ROW: begin
            ok_in = row_ok;
         end
         MODE_ROT_COL: begin
            ok_in     = col_ok;
            base_in   = AW'(req_col_index);
            stride_in = AW'(MAX_DIM);
            len_in    = rows_use;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // restoring remainder, one amount bit per cycle
   assign rem_sh   = {rem_ff, amt_ff[AMOUNT_W-1]};
   assign rem_step = (rem_sh >= (CW+1)'(len_ff)) ?
                     CW'(rem_sh - (CW+1)'(len_ff)) : CW'(rem_sh);
   assign src_next = ((src_ff + CW'(1)) == len_ff) ? '0 : (src_ff + CW'(1));

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rd_pend_in    = 1'b0;
      wr_pend_in    = 1'b0;
      amt_in        = amt_ff;
      div_cnt_in    = div_cnt_ff;
      rem_in        = rem_ff;
      src_in        = src_ff;
      k_in          = k_ff;
      line_addr_in  = line_addr_ff;
      rd_idx_in     = rd_idx_ff;
      wr_addr_in    = wr_addr_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_addr_ff;
      mem_wdata     = buf_q;
      buf_raddr     = src_ff[KW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // write-back stream from the line buffer
      if (wr_pend_ff) begin
         mem_we = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               line_addr_in = base_in;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_data_in   = '0;
            res_status_in = 1'b0;
            if (!ok_ff) begin
               res_status_in = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               unique case (mode_ff)
                  MODE_LOAD: begin
                     mem_we    = 1'b1;
                     mem_waddr = base_ff;
                     mem_wdata = value_ff;
                     state_in  = ST_FINISH;
                  end
                  MODE_READ: begin
                     state_in = ST_READ_WAIT;
                  end
                  MODE_ROT_ROW, MODE_ROT_COL: begin
                     amt_in     = value_ff[AMOUNT_W-1:0];
                     div_cnt_in = '0;
                     rem_in     = '0;
                     state_in   = (len_ff < CW'(2)) ? ST_FINISH : ST_DIVIDE;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in     = rem_step;
            amt_in     = amt_ff << 1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               if (rem_step == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  src_in       = toward_ff ? rem_step : (len_ff - rem_step);
                  k_in         = '0;
                  line_addr_in = base_ff;
                  state_in     = ST_READ_LINE;
               end
            end
         end
         ST_READ_LINE: begin
            if (k_ff < len_ff) begin
               rd_pend_in   = 1'b1;
               rd_idx_in    = k_ff[KW-1:0];
               k_in         = k_ff + CW'(1);
               line_addr_in = line_addr_ff + stride_ff;
            end else if (!rd_pend_ff) begin
               k_in         = '0;
               line_addr_in = base_ff;
               state_in     = ST_WRITE_LINE;
            end
         end
         ST_WRITE_LINE: begin
            if (k_ff < len_ff) begin
               wr_pend_in   = 1'b1;
               wr_addr_in   = line_addr_ff;
               src_in       = src_next;
               k_in         = k_ff + CW'(1);
               line_addr_in = line_addr_ff + stride_ff;
            end else if (!wr_pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ_WAIT: begin
            res_data_in = mem_q;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign buf_we = rd_pend_ff;

   // element store, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      mem_q <= store[line_addr_ff];
   end

   // line buffer, registered read
   always_ff @(posedge clock) begin
      if (buf_we) begin
         line_buf[rd_idx_ff] <= mem_q;
      end
      buf_q <= line_buf[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         row_count_ff <= COUNT_W'(1);
         col_count_ff <= COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         wr_pend_ff   <= wr_pend_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROW_COUNT: row_count_ff <= csr_wdata;
               CSR_COL_COUNT: col_count_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff   <= mode_in;
         ok_ff     <= ok_in;
         base_ff   <= base_in;
         stride_ff <= stride_in;
         len_ff    <= len_in;
         toward_ff <= toward_in;
         // amount rides in the low bits of the value register
         value_ff  <= (mode_in == MODE_LOAD) ? value_in : DATA_W'(req_amount);
      end
      amt_ff        <= amt_in;
      div_cnt_ff    <= div_cnt_in;
      rem_ff        <= rem_in;
      src_ff        <= src_in;
      k_ff          <= k_in;
      line_addr_ff  <= line_addr_in;
      rd_idx_ff     <= rd_idx_in;
      wr_addr_ff    <= wr_addr_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
